FILE: hw/rtl/fixed_point_arith_unit_core_defines.svh
// Assertion macros shared by the fixed-point unit RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef FIXED_POINT_ARITH_UNIT_CORE_DEFINES_SVH
`define FIXED_POINT_ARITH_UNIT_CORE_DEFINES_SVH

// Clocked property, ignored while reset is held low
`define FPAU_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge
`define FPAU_NEVER(label, clk, rst_n, cond, msg) \
    `FPAU_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

FILE: hw/rtl/fpau_pkg.sv
// Shared types and constants for the fixed-point arithmetic unit.
// No dependencies; imported by every module of the unit.
`default_nettype none

package fpau_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned EXP_W    = 8;
    localparam int unsigned MANT_W   = 23;
    localparam int unsigned EXP_BIAS = 127;

    // Opcodes
    localparam logic [1:0] OP_MUL  = 2'd0;
    localparam logic [1:0] OP_DIV  = 2'd1;
    localparam logic [1:0] OP_F2FX = 2'd2;
    localparam logic [1:0] OP_ABS  = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_DIV_ZERO  = 2'd1;
    localparam logic [1:0] ST_MUL_RANGE = 2'd2;

    typedef struct packed {
        logic [1:0]               opcode;
        logic signed [WORD_W-1:0] operand_a;
        logic signed [WORD_W-1:0] operand_b;
    } t_in_item;

    typedef struct packed {
        logic signed [WORD_W-1:0] value;
        logic [1:0]               status;
    } t_out_item;

    // Per-item side data that travels along the divider cells
    typedef struct packed {
        logic              use_quot;   // result comes from the quotient
        logic              neg;        // operand signs differ
        logic [WORD_W-1:0] mb;         // divisor magnitude
        logic [WORD_W-1:0] rem;        // partial remainder
        logic [WORD_W-1:0] byp_value;  // result of the other operations
        logic [1:0]        byp_status;
    } t_lane;

endpackage

`default_nettype wire

FILE: hw/rtl/fixed_point_arith_unit_core.sv
// Channel  Dir  Handshake                  Payload
// in       in   i_in_valid / o_in_stall    i_in_data  (t_in_item)
// out      out  o_out_valid / i_out_stall  o_out_data (t_out_item)
//
// One item enters per cycle while the result buffer has room; each result
// (16.16 by default) passes the front stages, the divider cell chain, one
// quotient bit per cell, and the buffer; every opcode does, so order holds.
// Reset clears all valid bits and the result buffer; no clearing pass.
// The pipeline stalls as a whole only when the two-entry result buffer is full.
//
// Top level of the fixed-point unit. Depends on fpau_pkg, fpau_front,
// fpau_div_cell and fpau_outbuf.
`default_nettype none

module fixed_point_arith_unit_core
    import fpau_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_data
);

    localparam int unsigned DW    = WORD_W + FRAC_BITS;
    localparam int unsigned NCELL = DW;

    logic           en;
    logic           buf_full;
    logic           c_valid [NCELL+1];
    t_lane          c_lane  [NCELL+1];
    logic [DW-1:0]  c_dq    [NCELL+1];
    t_lane          last_lane;
    logic [WORD_W-1:0] quot;
    t_out_item      res;

    // Whole pipeline moves while the buffer has room
    assign en         = !buf_full;
    assign o_in_stall = buf_full;

    fpau_front #(
        .FRAC_BITS(FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_item  (i_in_data),
        .o_valid (c_valid[0]),
        .o_lane  (c_lane[0]),
        .o_dq    (c_dq[0])
    );

    // Restoring divider, one cell per quotient bit
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        fpau_div_cell #(
            .DW(DW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (c_valid[g]),
            .i_lane  (c_lane[g]),
            .i_dq    (c_dq[g]),
            .o_valid (c_valid[g+1]),
            .o_lane  (c_lane[g+1]),
            .o_dq    (c_dq[g+1])
        );
    end

    // Sign the quotient or pass the other results through
    always_comb begin
        last_lane = c_lane[NCELL];
        quot      = c_dq[NCELL][WORD_W-1:0];
        if (last_lane.use_quot) begin
            res.value = last_lane.neg ? (WORD_W'(0) - quot) : quot;
        end else begin
            res.value = last_lane.byp_value;
        end
        res.status = last_lane.byp_status;
    end

    fpau_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (en && c_valid[NCELL]),
        .i_wr_data  (res),
        .i_rd_stall (i_out_stall),
        .o_full     (buf_full),
        .o_valid    (o_out_valid),
        .o_data     (o_out_data)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/fpau_front.sv
// Operand decode: multiply, float-to-fixed, abs, and divider setup.
// Depends on fpau_pkg. Two register stages, advanced by i_en.
`default_nettype none

module fpau_front
    import fpau_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16,
    localparam int unsigned DW = WORD_W + FRAC_BITS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire t_in_item      i_item,
    output logic               o_valid,
    output t_lane              o_lane,
    output logic [DW-1:0]      o_dq
);

    localparam int unsigned F2F_K = EXP_BIAS + MANT_W - FRAC_BITS;
    localparam logic [EXP_W-1:0] K8 = EXP_W'(F2F_K);

    // Stage A registers
    logic                     r_a_valid;
    logic [1:0]               r_op;
    logic signed [2*WORD_W-1:0] r_prod;
    logic [WORD_W-1:0]        r_ma;
    logic [WORD_W-1:0]        r_mb;
    logic                     r_neg;
    logic                     r_dz;
    logic [WORD_W-1:0]        r_simple;

    // Stage B registers
    logic                     r_b_valid;
    t_lane                    r_lane;
    logic [DW-1:0]            r_dq;

    logic signed [2*WORD_W-1:0] n_prod;
    logic [WORD_W-1:0]        n_ma;
    logic [WORD_W-1:0]        n_mb;
    logic [WORD_W-1:0]        n_simple;
    logic [WORD_W-1:0]        f2f_mag;
    logic [WORD_W-1:0]        m32;
    logic [EXP_W-1:0]         f_exp;
    logic [EXP_W-1:0]         lsh;
    logic [EXP_W-1:0]         rsh;

    logic signed [2*WORD_W-1:0] sh_prod;
    logic [WORD_W-1:0]        hi_word;
    logic                     mul_ok;
    t_lane                    n_lane;

    // Stage A: multiply, magnitudes, float conversion, abs
    always_comb begin
        n_prod = i_item.operand_a * i_item.operand_b;
        n_ma = i_item.operand_a[WORD_W-1] ? (WORD_W'(0) - WORD_W'(i_item.operand_a))
                                          : WORD_W'(i_item.operand_a);
        n_mb = i_item.operand_b[WORD_W-1] ? (WORD_W'(0) - WORD_W'(i_item.operand_b))
                                          : WORD_W'(i_item.operand_b);

        // hidden bit always set
        f_exp = i_item.operand_a[WORD_W-2 -: EXP_W];
        m32 = {{(WORD_W-MANT_W-1){1'b0}}, 1'b1, i_item.operand_a[MANT_W-1:0]};
        lsh = f_exp - K8;
        rsh = K8 - f_exp;
        if (f_exp >= K8) begin
            f2f_mag = (lsh < EXP_W'(WORD_W)) ? (m32 << lsh[4:0]) : '0;
        end else begin
            f2f_mag = (rsh < EXP_W'(WORD_W)) ? (m32 >> rsh[4:0]) : '0;
        end

        if (i_item.opcode == OP_F2FX) begin
            n_simple = i_item.operand_a[WORD_W-1] ? (WORD_W'(0) - f2f_mag) : f2f_mag;
        end else begin
            n_simple = n_ma;  // abs wraps: most negative word maps to itself
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_op     <= i_item.opcode;
            r_prod   <= n_prod;
            r_ma     <= n_ma;
            r_mb     <= n_mb;
            r_neg    <= i_item.operand_a[WORD_W-1] ^ i_item.operand_b[WORD_W-1];
            r_dz     <= (i_item.operand_b == '0);
            r_simple <= n_simple;
        end
    end

    // Stage B: scale the product, range check, seed the divider
    always_comb begin
        sh_prod = r_prod >>> FRAC_BITS;
        hi_word = sh_prod[2*WORD_W-1:WORD_W];
        // in range when -2^32 < shifted product < 2^32
        mul_ok = (hi_word == '0) || ((hi_word == '1) && (sh_prod[WORD_W-1:0] != '0));

        n_lane.use_quot = (r_op == OP_DIV) && !r_dz;
        n_lane.neg      = r_neg;
        n_lane.mb       = r_mb;
        n_lane.rem      = '0;
        case (r_op)
            OP_MUL: begin
                n_lane.byp_value  = sh_prod[WORD_W-1:0];
                n_lane.byp_status = mul_ok ? ST_OK : ST_MUL_RANGE;
            end
            OP_DIV: begin
                n_lane.byp_value  = '0;
                n_lane.byp_status = r_dz ? ST_DIV_ZERO : ST_OK;
            end
            default: begin
                n_lane.byp_value  = r_simple;
                n_lane.byp_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
            r_dq   <= {r_ma, {FRAC_BITS{1'b0}}};
        end
    end

    assign o_valid = r_b_valid;
    assign o_lane  = r_lane;
    assign o_dq    = r_dq;

endmodule

`default_nettype wire

FILE: hw/rtl/fpau_div_cell.sv
// One restoring-division step: one quotient bit per cell, then a register.
// Depends on fpau_pkg. Cells are chained in the top level.
`default_nettype none

module fpau_div_cell
    import fpau_pkg::*;
#(
    parameter int unsigned DW = 48
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire t_lane         i_lane,
    input  wire logic [DW-1:0] i_dq,
    output logic               o_valid,
    output t_lane              o_lane,
    output logic [DW-1:0]      o_dq
);

    logic                r_valid;
    t_lane               r_lane;
    logic [DW-1:0]       r_dq;

    logic [WORD_W:0]     trial;
    logic [WORD_W+1:0]   diff;
    logic                ge;
    t_lane               n_lane;

    // Shift in the next dividend bit, try the subtract
    always_comb begin
        trial = {i_lane.rem, i_dq[DW-1]};
        diff  = {1'b0, trial} - {2'b00, i_lane.mb};
        ge    = ~diff[WORD_W+1];
        n_lane     = i_lane;
        n_lane.rem = ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Dividend bits leave at the top, quotient bits enter at the bottom
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
            r_dq   <= {i_dq[DW-2:0], ge};
        end
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;
    assign o_dq    = r_dq;

endmodule

`default_nettype wire

FILE: hw/rtl/fpau_outbuf.sv
// Two-entry result buffer between the pipeline and the output channel.
// Depends on fpau_pkg and the assertion macro header.
`default_nettype none
`include "fixed_point_arith_unit_core_defines.svh"

module fpau_outbuf
    import fpau_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_wr_en,
    input  wire t_out_item i_wr_data,
    input  wire logic      i_rd_stall,
    output logic           o_full,
    output logic           o_valid,
    output t_out_item      o_data
);

    t_out_item   r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;

    logic        rd_en;
    logic [1:0]  n_count;

    assign rd_en   = o_valid && !i_rd_stall;
    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count + 2'(i_wr_en) - 2'(rd_en);
    end

    // Pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_wr_en) r_wr_ptr <= ~r_wr_ptr;
            if (rd_en)   r_rd_ptr <= ~r_rd_ptr;
            r_count <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    `FPAU_NEVER(a_count_range, i_clk, i_rst_n, r_count == 2'd3, "result buffer count overflow")
    `FPAU_NEVER(a_no_write_full, i_clk, i_rst_n, i_wr_en && o_full, "write into full result buffer")
    `FPAU_ASSERT(a_drain_count, i_clk, i_rst_n, (rd_en && !i_wr_en) |=> (r_count == $past(r_count) - 2'd1), "count did not drop after transfer")

endmodule

`default_nettype wire
